// File: rtl/qn_pkg.sv
// Shared widths, constants, beat types and register codes for the quaternion normalizer.
package qn_pkg;

	// Component format: signed Q1.F with F = COMP_WIDTH - 2
	localparam int COMP_WIDTH = 16;
	localparam int FRAC_BITS  = COMP_WIDTH - 2;
	localparam int NUM_LANES  = 4;

	// Datapath widths
	localparam int MAG_W   = COMP_WIDTH;              // |component|, up to 2^(W-1)
	localparam int SQ_W    = 2 * COMP_WIDTH;          // squared magnitude
	localparam int NORM_W  = 2 * COMP_WIDTH + 1;      // sum of four squares
	localparam int CFG_W   = 32;                      // widest register
	localparam int CMP_W   = (NORM_W > CFG_W) ? NORM_W : CFG_W;
	localparam int RES_W   = 4 * COMP_WIDTH + 2;      // signed residual of the root recurrence
	localparam int UPD_W   = 3 * COMP_WIDTH + 1;      // signed (2k-1)*N term
	localparam int K_W     = FRAC_BITS + 1;           // quotient, up to 2^F
	localparam int A_SHIFT = 2 * FRAC_BITS + 2;       // (m << (F+1))^2 = m^2 << (2F+2)
	localparam int ROOT_STAGES = FRAC_BITS + 1;       // one quotient bit per stage
	localparam int CFG_IDX_W = 2;

	localparam logic signed [COMP_WIDTH-1:0] UNIT_ONE = COMP_WIDTH'(1) << FRAC_BITS;
	localparam logic [CMP_W-1:0] NORM_ONE = CMP_W'(1) << (2 * FRAC_BITS);

	// Register reset values
	localparam logic             DROP_DEGEN_RST   = 1'b1;
	localparam logic [CFG_W-1:0] MIN_NORM_SQ_RST  = CFG_W'(1);
	localparam logic [CFG_W-1:0] UNIT_TOL_RST     = CFG_W'(268);

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DROP_DEGEN   = CFG_IDX_W'(0),
		CFG_MIN_NORM_SQ  = CFG_IDX_W'(1),
		CFG_UNIT_TOL     = CFG_IDX_W'(2)
	} cfg_idx_t;

	typedef struct packed {
		logic             drop_degen;
		logic [CFG_W-1:0] min_norm_sq;
		logic [CFG_W-1:0] unit_tolerance;
	} cfg_t;

	typedef struct packed {
		logic signed [COMP_WIDTH-1:0] in_x;
		logic signed [COMP_WIDTH-1:0] in_y;
		logic signed [COMP_WIDTH-1:0] in_z;
		logic signed [COMP_WIDTH-1:0] in_w;
	} in_beat_t;

	typedef struct packed {
		logic signed [COMP_WIDTH-1:0] out_x;
		logic signed [COMP_WIDTH-1:0] out_y;
		logic signed [COMP_WIDTH-1:0] out_z;
		logic signed [COMP_WIDTH-1:0] out_w;
		logic                         status;
		logic                         off_unit;
	} out_beat_t;

	// One component inside the root recurrence
	typedef struct packed {
		logic                    neg;
		logic [K_W-1:0]          k;
		logic signed [RES_W-1:0] res;
		logic signed [UPD_W-1:0] upd;
	} lane_t;

	// Item state carried through the root stages
	typedef struct packed {
		lane_t [NUM_LANES-1:0] lane;
		logic [NORM_W-1:0]     norm;
		logic                  ident;
		logic                  off_unit;
	} root_t;

endpackage

// File: rtl/qn_front.sv
// Front stages: magnitudes, squares, squared norm, degenerate and off-unit checks.
module qn_front (
	input  logic              clk,
	input  logic              arst_n,
	input  qn_pkg::cfg_t      cfg,
	input  logic              up_valid,
	output logic              up_ready,
	input  qn_pkg::in_beat_t  up_data,
	output logic              dn_valid,
	input  logic              dn_ready,
	output qn_pkg::root_t     dn_data
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;

	logic [qn_pkg::MAG_W-1:0]  mag_s1 [qn_pkg::NUM_LANES];
	logic                      neg_s1 [qn_pkg::NUM_LANES];
	logic [qn_pkg::SQ_W-1:0]   sq_s2  [qn_pkg::NUM_LANES];
	logic                      neg_s2 [qn_pkg::NUM_LANES];
	logic [qn_pkg::SQ_W-1:0]   sq_s3  [qn_pkg::NUM_LANES];
	logic                      neg_s3 [qn_pkg::NUM_LANES];
	logic [qn_pkg::NORM_W-1:0] norm_s3;
	qn_pkg::root_t             item_s4;

	logic signed [qn_pkg::COMP_WIDTH-1:0] comp [qn_pkg::NUM_LANES];
	logic [qn_pkg::CMP_W-1:0] norm_c, dev;
	logic                     degen, keep;
	qn_pkg::root_t            item_nxt;

	// Stage handshake: a stage takes a beat when empty or when it drains
	assign rdy_s4   = !v_s4 || dn_ready;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign up_ready = rdy_s1;

	assign comp[0] = up_data.in_x;
	assign comp[1] = up_data.in_y;
	assign comp[2] = up_data.in_z;
	assign comp[3] = up_data.in_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= up_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3 && keep;
		end
	end

	// s1: sign and magnitude (most negative code maps to 2^(W-1))
	always_ff @(posedge clk) begin
		if (rdy_s1 && up_valid) begin
			for (int ln = 0; ln < qn_pkg::NUM_LANES; ln++) begin
				neg_s1[ln] <= comp[ln][qn_pkg::COMP_WIDTH-1];
				mag_s1[ln] <= comp[ln][qn_pkg::COMP_WIDTH-1]
					? qn_pkg::MAG_W'(-comp[ln]) : qn_pkg::MAG_W'(comp[ln]);
			end
		end
	end

	// s2: one square per lane
	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			for (int ln = 0; ln < qn_pkg::NUM_LANES; ln++) begin
				sq_s2[ln]  <= qn_pkg::SQ_W'(mag_s1[ln]) * qn_pkg::SQ_W'(mag_s1[ln]);
				neg_s2[ln] <= neg_s1[ln];
			end
		end
	end

	// s3: squared norm, exact
	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s2) begin
			norm_s3 <= qn_pkg::NORM_W'(sq_s2[0]) + qn_pkg::NORM_W'(sq_s2[1])
				+ qn_pkg::NORM_W'(sq_s2[2]) + qn_pkg::NORM_W'(sq_s2[3]);
			for (int ln = 0; ln < qn_pkg::NUM_LANES; ln++) begin
				sq_s3[ln]  <= sq_s2[ln];
				neg_s3[ln] <= neg_s2[ln];
			end
		end
	end

	// s4 inputs: classify and seed the root recurrence with k = 0
	always_comb begin
		norm_c = qn_pkg::CMP_W'(norm_s3);
		degen  = (norm_s3 == '0) || (norm_c < qn_pkg::CMP_W'(cfg.min_norm_sq));
		keep   = !(degen && cfg.drop_degen);
		dev    = (norm_c >= qn_pkg::NORM_ONE) ? norm_c - qn_pkg::NORM_ONE
			: qn_pkg::NORM_ONE - norm_c;
		item_nxt.norm     = norm_s3;
		item_nxt.ident    = degen;
		item_nxt.off_unit = !degen && (dev > qn_pkg::CMP_W'(cfg.unit_tolerance));
		for (int ln = 0; ln < qn_pkg::NUM_LANES; ln++) begin
			item_nxt.lane[ln].neg = neg_s3[ln];
			item_nxt.lane[ln].k   = '0;
			// residual = A - (2k-1)^2 N with k = 0
			item_nxt.lane[ln].res = (qn_pkg::RES_W'(sq_s3[ln]) << qn_pkg::A_SHIFT)
				- qn_pkg::RES_W'(norm_s3);
			// (2k-1) N with k = 0
			item_nxt.lane[ln].upd = qn_pkg::UPD_W'(0) - qn_pkg::UPD_W'(norm_s3);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4 && v_s3) begin
			item_s4 <= item_nxt;
		end
	end

	assign dn_valid = v_s4;
	assign dn_data  = item_s4;

endmodule

// File: rtl/qn_root_pipe.sv
// Rounded m * 2^F / sqrt(N) per lane, one quotient bit per pipeline stage.
module qn_root_pipe (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          up_valid,
	output logic          up_ready,
	input  qn_pkg::root_t up_data,
	output logic          dn_valid,
	input  logic          dn_ready,
	output qn_pkg::root_t dn_data
);

	localparam int NSTG = qn_pkg::ROOT_STAGES;

	logic          iter_valid_s [NSTG];
	qn_pkg::root_t iter_data_s  [NSTG];
	logic          stg_rdy      [NSTG];

	assign up_ready = stg_rdy[0];
	assign dn_valid = iter_valid_s[NSTG-1];
	assign dn_data  = iter_data_s[NSTG-1];

	// Recurrence on k, bit b from F down to 0, with cand = k + 2^b:
	//   res' = res - (upd << (b+2)) - (N << (2b+2))   (= A - (2cand-1)^2 N)
	//   accept when res' >= 0 and k has not reached 1.0
	//   then upd' = upd + (N << (b+1))                (= (2cand-1) N)
	for (genvar st = 0; st < NSTG; st++) begin : g_stg
		localparam int BIT = qn_pkg::FRAC_BITS - st;

		logic                            cur_valid;
		qn_pkg::root_t                   cur, nxt;
		logic                            nxt_rdy;
		logic signed [qn_pkg::RES_W-1:0] upd_ext [qn_pkg::NUM_LANES];
		logic signed [qn_pkg::RES_W-1:0] trial   [qn_pkg::NUM_LANES];
		logic signed [qn_pkg::RES_W-1:0] norm_ext;

		if (st == 0) begin : g_head
			assign cur_valid = up_valid;
			assign cur       = up_data;
		end else begin : g_body
			assign cur_valid = iter_valid_s[st-1];
			assign cur       = iter_data_s[st-1];
		end

		if (st == NSTG - 1) begin : g_tail
			assign nxt_rdy = dn_ready;
		end else begin : g_mid
			assign nxt_rdy = stg_rdy[st+1];
		end

		assign stg_rdy[st] = !iter_valid_s[st] || nxt_rdy;
		assign norm_ext    = qn_pkg::RES_W'(cur.norm);

		always_comb begin
			nxt = cur;
			for (int ln = 0; ln < qn_pkg::NUM_LANES; ln++) begin
				upd_ext[ln] = {{(qn_pkg::RES_W - qn_pkg::UPD_W){cur.lane[ln].upd[qn_pkg::UPD_W-1]}},
					cur.lane[ln].upd};
				trial[ln] = cur.lane[ln].res - (upd_ext[ln] <<< (BIT + 2))
					- (norm_ext << (2 * BIT + 2));
				if (!cur.lane[ln].k[qn_pkg::FRAC_BITS] && !trial[ln][qn_pkg::RES_W-1]) begin
					nxt.lane[ln].k   = cur.lane[ln].k | (qn_pkg::K_W'(1) << BIT);
					nxt.lane[ln].res = trial[ln];
					nxt.lane[ln].upd = cur.lane[ln].upd
						+ (qn_pkg::UPD_W'(cur.norm) << (BIT + 1));
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				iter_valid_s[st] <= 1'b0;
			end else if (stg_rdy[st]) begin
				iter_valid_s[st] <= cur_valid;
			end
		end

		always_ff @(posedge clk) begin
			if (stg_rdy[st] && cur_valid) begin
				iter_data_s[st] <= nxt;
			end
		end
	end

endmodule

// File: rtl/qn_back.sv
// Output stage: restores signs, substitutes the identity, holds the result beat.
module qn_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              up_valid,
	output logic              up_ready,
	input  qn_pkg::root_t     up_data,
	output logic              dn_valid,
	input  logic              dn_ready,
	output qn_pkg::out_beat_t dn_data
);

	logic              out_valid_q;
	qn_pkg::out_beat_t out_data_q;
	qn_pkg::out_beat_t beat_nxt;
	logic signed [qn_pkg::COMP_WIDTH-1:0] comp [qn_pkg::NUM_LANES];

	assign up_ready = !out_valid_q || dn_ready;

	// Signed result per lane; k <= 2^F always fits below the largest positive code
	always_comb begin
		for (int ln = 0; ln < qn_pkg::NUM_LANES; ln++) begin
			comp[ln] = up_data.lane[ln].neg
				? qn_pkg::COMP_WIDTH'(0) - qn_pkg::COMP_WIDTH'(up_data.lane[ln].k)
				: qn_pkg::COMP_WIDTH'(up_data.lane[ln].k);
		end
		if (up_data.ident) begin
			beat_nxt.out_x    = '0;
			beat_nxt.out_y    = '0;
			beat_nxt.out_z    = '0;
			beat_nxt.out_w    = qn_pkg::UNIT_ONE;
			beat_nxt.status   = 1'b1;
			beat_nxt.off_unit = 1'b0;
		end else begin
			beat_nxt.out_x    = comp[0];
			beat_nxt.out_y    = comp[1];
			beat_nxt.out_z    = comp[2];
			beat_nxt.out_w    = comp[3];
			beat_nxt.status   = 1'b0;
			beat_nxt.off_unit = up_data.off_unit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (up_ready) begin
			out_valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			out_data_q <= beat_nxt;
		end
	end

	assign dn_valid = out_valid_q;
	assign dn_data  = out_data_q;

endmodule

// File: rtl/quaternion_normalizer.sv
// Top level of the quaternion normalizer: register file, pipeline and checks.
//
// Takes one Q1.14 quaternion per beat and returns it scaled to unit length, each
// component rounded to nearest (halves away from zero), or drops it / replaces it
// with the identity when its squared norm (Q5.28) is zero or below min_norm_sq.
// The pipeline accepts one beat every cycle while the output drains. It has
// four front stages (magnitude, square, norm sum, classification), fifteen
// stages of the bit-serial inverse-square-root recurrence, one quotient bit per
// stage for all four components in parallel, and one output register. Dropped
// beats leave bubbles, and back-pressure stalls only the stages that are full,
// so input is still taken while a result waits and a stage is empty. Registers
// take effect for beats that reach classification after the write; write them
// only when the block holds no beat.
module quaternion_normalizer (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  qn_pkg::in_beat_t                 in_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output qn_pkg::out_beat_t                out_data,
	input  logic                             cfg_we,
	input  logic [qn_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [qn_pkg::CFG_W-1:0]         cfg_wdata
);

	logic                     drop_degen_q;
	logic [qn_pkg::CFG_W-1:0] min_norm_sq_q;
	logic [qn_pkg::CFG_W-1:0] unit_tol_q;
	qn_pkg::cfg_t             cfg;

	logic          fr_valid, fr_ready;
	qn_pkg::root_t fr_data;
	logic          rt_valid, rt_ready;
	qn_pkg::root_t rt_data;

	// Register writes; unused index is ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drop_degen_q   <= qn_pkg::DROP_DEGEN_RST;
			min_norm_sq_q  <= qn_pkg::MIN_NORM_SQ_RST;
			unit_tol_q     <= qn_pkg::UNIT_TOL_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				qn_pkg::CFG_DROP_DEGEN:   drop_degen_q   <= cfg_wdata[0];
				qn_pkg::CFG_MIN_NORM_SQ:  min_norm_sq_q  <= cfg_wdata;
				qn_pkg::CFG_UNIT_TOL:     unit_tol_q     <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg.drop_degen     = drop_degen_q;
	assign cfg.min_norm_sq    = min_norm_sq_q;
	assign cfg.unit_tolerance = unit_tol_q;

	qn_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.up_valid (in_valid),
		.up_ready (in_ready),
		.up_data  (in_data),
		.dn_valid (fr_valid),
		.dn_ready (fr_ready),
		.dn_data  (fr_data)
	);

	qn_root_pipe u_root (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (fr_valid),
		.up_ready (fr_ready),
		.up_data  (fr_data),
		.dn_valid (rt_valid),
		.dn_ready (rt_ready),
		.dn_data  (rt_data)
	);

	qn_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (rt_valid),
		.up_ready (rt_ready),
		.up_data  (rt_data),
		.dn_valid (out_valid),
		.dn_ready (out_ready),
		.dn_data  (out_data)
	);

`ifndef ASSERT_OFF
	// An empty or draining output register opens every stage back to the input
	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid || out_ready) |-> in_ready)
		else $error("input stalled while output side can drain");

	// Identity beats carry exact identity payload and never the off-unit flag
	a_ident_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.status) |-> (out_data.out_x == '0 && out_data.out_y == '0
			&& out_data.out_z == '0 && out_data.out_w == qn_pkg::UNIT_ONE
			&& !out_data.off_unit))
		else $error("identity beat with wrong payload");

	// Degenerate beats only reach the output when dropping is off
	a_no_ident_when_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.status) |-> !drop_degen_q)
		else $error("degenerate beat delivered while dropping");

	// Normalized components never exceed 1.0 in magnitude
	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.status) |->
			(out_data.out_x <= qn_pkg::UNIT_ONE && out_data.out_x >= -qn_pkg::UNIT_ONE
			&& out_data.out_y <= qn_pkg::UNIT_ONE && out_data.out_y >= -qn_pkg::UNIT_ONE
			&& out_data.out_z <= qn_pkg::UNIT_ONE && out_data.out_z >= -qn_pkg::UNIT_ONE
			&& out_data.out_w <= qn_pkg::UNIT_ONE && out_data.out_w >= -qn_pkg::UNIT_ONE))
		else $error("normalized component beyond unit magnitude");
`endif

endmodule
